FILE: rtl/mgmc_pkg.sv
// ----------------------------------------------------------------------------
// mgmc_pkg
// Shared types, codes and helpers of the motor guard mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mgmc_pkg;

   // guard modes
   typedef enum logic [2:0] {
      MODE_OFFLINE   = 3'd0,
      MODE_STOPPED   = 3'd1,
      MODE_OPERATING = 3'd2,
      MODE_MAINT     = 3'd3,
      MODE_LOCKED    = 3'd4
   } mode_type;

   // item kinds
   localparam logic [1:0] FUNC_COMMAND = 2'd0;
   localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
   localparam logic [1:0] FUNC_LINK    = 2'd2;

   // command codes
   localparam logic [2:0] CMD_START     = 3'd0;
   localparam logic [2:0] CMD_STOP      = 3'd1;
   localparam logic [2:0] CMD_MAINT     = 3'd2;
   localparam logic [2:0] CMD_RESET     = 3'd3;
   localparam logic [2:0] CMD_SWITCH_ID = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_TEMP_LIMIT    = 3'd0;
   localparam logic [2:0] CSR_CURRENT_LIMIT = 3'd1;
   localparam logic [2:0] CSR_VIB_LIMIT     = 3'd2;
   localparam logic [2:0] CSR_TRIP_DELAY    = 3'd3;
   localparam logic [2:0] CSR_SWEEP_STEP    = 3'd4;

   // register reset values
   localparam logic [11:0] TEMP_LIMIT_RST    = 12'd600;
   localparam logic [11:0] CURRENT_LIMIT_RST = 12'd3822;
   localparam logic [15:0] VIB_LIMIT_RST     = 16'd1000;
   localparam logic [15:0] TRIP_DELAY_RST    = 16'd5000;
   localparam logic [5:0]  SWEEP_STEP_RST    = 6'd5;

   localparam logic [15:0] UNIT_ID_RST = 16'd1;

   // servo angles
   localparam logic [7:0] ANGLE_MAX  = 8'd180;
   localparam logic [7:0] ANGLE_IDLE = 8'd90;

   // blink: 500 ms period, on for the first 250 ms
   localparam logic [8:0] BLINK_ON   = 9'd250;
   localparam logic [8:0] BLINK_QTR  = 9'd125;

   // led phase of a timestamp: (t mod 500) < 250
   // t mod 500 = 4 * ((t >> 2) mod 125) + t[1:0]; the mod 125 folds 7-bit digits
   // using 2^7 = 3, 2^14 = 9, 2^21 = 27, 2^28 = 81 (mod 125)
   function automatic logic blink_phase(input logic [31:0] t);
      logic [29:0] q;
      logic [12:0] fold1;
      logic [8:0]  fold2;
      logic [8:0]  rem;
      logic [8:0]  phase;
      q     = t[31:2];
      fold1 = 13'(q[6:0])
            + 13'(q[13:7])  * 13'd3
            + 13'(q[20:14]) * 13'd9
            + 13'(q[27:21]) * 13'd27
            + 13'(q[29:28]) * 13'd81;
      fold2 = 9'(fold1[6:0]) + 9'(fold1[12:7]) * 9'd3;
      rem   = fold2;
      if (rem >= BLINK_ON) begin
         rem = rem - BLINK_ON;
      end
      if (rem >= BLINK_QTR) begin
         rem = rem - BLINK_QTR;
      end
      phase = {rem[6:0], t[1:0]};
      return (phase < BLINK_ON);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/motor_guard_mode_controller_unit.sv
// ----------------------------------------------------------------------------
// motor_guard_mode_controller_unit
// Five-mode motor guard: commands, link changes and sensor samples update the
// mode, fault timer and servo sweep; one result item per input item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  req     | in        | req_valid/req_ready | func, ids, command, sensors, time
//  rsp     | out       | rsp_valid/rsp_ready | mode, unit id, servo, led, flags
//  csr     | in        | csr_valid/csr_ready | register index, write data
//
// one item per cycle sustained while results are taken; an accepted item passes
// through the input register, then the result register
// the mode and sweep update sits between the input and result registers
// a stalled result holds the result register; the input register still takes
// one more item, then ready drops until the result is taken
// synchronous reset clears fault timer and sweep, sets mode offline, reloads id and limits
// ----------------------------------------------------------------------------
`default_nettype none

module motor_guard_mode_controller_unit #(
   parameter int TIMESTAMP_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // item input
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_func,
   input  wire logic [15:0]        req_target_id,
   input  wire logic [2:0]         req_command,
   input  wire logic [15:0]        req_new_id,
   input  wire logic signed [11:0] req_temperature,
   input  wire logic [11:0]        req_current_raw,
   input  wire logic signed [15:0] req_vibration,
   input  wire logic [31:0]        req_now_ms,
   input  wire logic               req_link_up,
   // result output
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_mode,
   output logic [15:0]             rsp_unit_id,
   output logic [7:0]              rsp_servo_angle,
   output logic                    rsp_led_on,
   output logic                    rsp_critical,
   output logic                    rsp_trip_now,
   // register writes
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   // timestamp bits actually carried by the 32-bit port
   localparam int TS_W = (TIMESTAMP_BITS < 32) ? TIMESTAMP_BITS : 32;

   // configuration registers
   logic signed [11:0] temp_limit_ff;
   logic [11:0]        current_limit_ff;
   logic signed [15:0] vib_limit_ff;
   logic [15:0]        trip_delay_ff;
   logic [5:0]         sweep_step_ff;

   // guard state
   mgmc_pkg::mode_type mode_ff, mode_in;
   logic [15:0]        unit_id_ff, unit_id_in;
   logic               fault_pending_ff, fault_pending_in;
   logic [TS_W-1:0]    fault_start_ff, fault_start_in;
   logic signed [8:0]  servo_pos_ff, servo_pos_in;
   logic               sweep_down_ff, sweep_down_in;

   // input register
   logic               s1_valid_ff;
   logic [1:0]         s1_func_ff;
   logic [15:0]        s1_target_id_ff;
   logic [2:0]         s1_command_ff;
   logic [15:0]        s1_new_id_ff;
   logic signed [11:0] s1_temperature_ff;
   logic [11:0]        s1_current_raw_ff;
   logic signed [15:0] s1_vibration_ff;
   logic [TS_W-1:0]    s1_now_ff;
   logic               s1_link_up_ff;
   logic               s1_blink_ff;

   // result register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_mode_ff;
   logic [15:0]        rsp_unit_id_ff;
   logic [7:0]         rsp_servo_angle_ff;
   logic               rsp_led_on_ff;
   logic               rsp_critical_ff;
   logic               rsp_trip_now_ff;

   // result of the current item
   logic [7:0]         angle_in;
   logic               led_in;
   logic               critical_in;
   logic               trip_in;

   // flow control
   logic               out_load;
   logic               advance;

   // sweep arithmetic
   logic signed [9:0]  sweep_sum;
   logic signed [8:0]  sweep_sat;
   logic               sweep_flip;

   // fault timer
   logic [TIMESTAMP_BITS-1:0] elapsed;
   logic                      delay_done;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_load;
   assign req_ready = !s1_valid_ff || out_load;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_limit_ff    <= mgmc_pkg::TEMP_LIMIT_RST;
         current_limit_ff <= mgmc_pkg::CURRENT_LIMIT_RST;
         vib_limit_ff     <= mgmc_pkg::VIB_LIMIT_RST;
         trip_delay_ff    <= mgmc_pkg::TRIP_DELAY_RST;
         sweep_step_ff    <= mgmc_pkg::SWEEP_STEP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            mgmc_pkg::CSR_TEMP_LIMIT:    temp_limit_ff    <= csr_data[11:0];
            mgmc_pkg::CSR_CURRENT_LIMIT: current_limit_ff <= csr_data[11:0];
            mgmc_pkg::CSR_VIB_LIMIT:     vib_limit_ff     <= csr_data;
            mgmc_pkg::CSR_TRIP_DELAY:    trip_delay_ff    <= csr_data;
            mgmc_pkg::CSR_SWEEP_STEP:    sweep_step_ff    <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // input register payload, led phase taken from the masked timestamp
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_func_ff        <= req_func;
         s1_target_id_ff   <= req_target_id;
         s1_command_ff     <= req_command;
         s1_new_id_ff      <= req_new_id;
         s1_temperature_ff <= req_temperature;
         s1_current_raw_ff <= req_current_raw;
         s1_vibration_ff   <= req_vibration;
         s1_now_ff         <= req_now_ms[TS_W-1:0];
         s1_link_up_ff     <= req_link_up;
         s1_blink_ff       <= mgmc_pkg::blink_phase(32'(req_now_ms[TS_W-1:0]));
      end
   end

   // servo step with saturation to the 9-bit stored range
   assign sweep_sum = sweep_down_ff
                    ? (10'(servo_pos_ff) - $signed({4'b0000, sweep_step_ff}))
                    : (10'(servo_pos_ff) + $signed({4'b0000, sweep_step_ff}));

   always_comb begin
      if (sweep_sum > 10'sd255) begin
         sweep_sat = 9'sd255;
      end else if (sweep_sum < -10'sd256) begin
         sweep_sat = -9'sd256;
      end else begin
         sweep_sat = sweep_sum[8:0];
      end
   end

   assign sweep_flip = (sweep_sat >= $signed({1'b0, mgmc_pkg::ANGLE_MAX}))
                    || (sweep_sat <= 9'sd0);

   // time since the violation was first seen, wrapping at the timestamp width
   assign elapsed    = TIMESTAMP_BITS'(s1_now_ff) - TIMESTAMP_BITS'(fault_start_ff);
   assign delay_done = (elapsed >= TIMESTAMP_BITS'(trip_delay_ff));

   // next state and result of the item in the input register
   always_comb begin
      mode_in          = mode_ff;
      unit_id_in       = unit_id_ff;
      fault_pending_in = fault_pending_ff;
      fault_start_in   = fault_start_ff;
      servo_pos_in     = servo_pos_ff;
      sweep_down_in    = sweep_down_ff;
      critical_in      = 1'b0;
      trip_in          = 1'b0;

      case (s1_func_ff)
         mgmc_pkg::FUNC_COMMAND: begin
            if (s1_target_id_ff == unit_id_ff) begin
               if (s1_command_ff == mgmc_pkg::CMD_SWITCH_ID) begin
                  if (s1_new_id_ff != 16'd0) begin
                     unit_id_in = s1_new_id_ff;
                  end
               end else begin
                  case (mode_ff)
                     mgmc_pkg::MODE_LOCKED: begin
                        if (s1_command_ff == mgmc_pkg::CMD_MAINT) begin
                           mode_in = mgmc_pkg::MODE_MAINT;
                        end
                     end
                     mgmc_pkg::MODE_MAINT: begin
                        if (s1_command_ff == mgmc_pkg::CMD_RESET) begin
                           mode_in = mgmc_pkg::MODE_STOPPED;
                        end
                     end
                     default: begin
                        if (s1_command_ff == mgmc_pkg::CMD_START) begin
                           mode_in = mgmc_pkg::MODE_OPERATING;
                        end else if (s1_command_ff == mgmc_pkg::CMD_STOP) begin
                           mode_in = mgmc_pkg::MODE_STOPPED;
                        end else if (s1_command_ff == mgmc_pkg::CMD_MAINT) begin
                           mode_in = mgmc_pkg::MODE_MAINT;
                        end
                     end
                  endcase
               end
            end
         end
         mgmc_pkg::FUNC_LINK: begin
            if (!s1_link_up_ff) begin
               mode_in = mgmc_pkg::MODE_OFFLINE;
            end else if (mode_ff == mgmc_pkg::MODE_OFFLINE) begin
               mode_in = mgmc_pkg::MODE_STOPPED;
            end
         end
         mgmc_pkg::FUNC_SAMPLE: begin
            critical_in = (s1_temperature_ff >= temp_limit_ff)
                       || (s1_current_raw_ff >= current_limit_ff)
                       || (s1_vibration_ff >= vib_limit_ff);
            // first violation arms the timer, a later one may trip
            if (critical_in && (mode_ff == mgmc_pkg::MODE_OPERATING)) begin
               if (!fault_pending_ff) begin
                  fault_pending_in = 1'b1;
                  fault_start_in   = s1_now_ff;
               end else if (delay_done) begin
                  mode_in          = mgmc_pkg::MODE_LOCKED;
                  fault_pending_in = 1'b0;
                  trip_in          = 1'b1;
               end
            end else begin
               fault_pending_in = 1'b0;
            end
            // sweep only if still operating after the fault check
            if (mode_in == mgmc_pkg::MODE_OPERATING) begin
               servo_pos_in = sweep_sat;
               if (sweep_flip) begin
                  sweep_down_in = !sweep_down_ff;
               end
            end
         end
         default: ;
      endcase

      // servo and led follow the mode after this item
      if (mode_in == mgmc_pkg::MODE_OPERATING) begin
         if (servo_pos_in < 9'sd0) begin
            angle_in = 8'd0;
         end else if (servo_pos_in > $signed({1'b0, mgmc_pkg::ANGLE_MAX})) begin
            angle_in = mgmc_pkg::ANGLE_MAX;
         end else begin
            angle_in = servo_pos_in[7:0];
         end
         led_in = 1'b1;
      end else begin
         angle_in = mgmc_pkg::ANGLE_IDLE;
         led_in   = (mode_in == mgmc_pkg::MODE_LOCKED) && s1_blink_ff;
      end
   end

   // guard state register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= mgmc_pkg::MODE_OFFLINE;
         unit_id_ff       <= mgmc_pkg::UNIT_ID_RST;
         fault_pending_ff <= 1'b0;
         fault_start_ff   <= '0;
         servo_pos_ff     <= 9'sd0;
         sweep_down_ff    <= 1'b0;
      end else if (advance) begin
         mode_ff          <= mode_in;
         unit_id_ff       <= unit_id_in;
         fault_pending_ff <= fault_pending_in;
         fault_start_ff   <= fault_start_in;
         servo_pos_ff     <= servo_pos_in;
         sweep_down_ff    <= sweep_down_in;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mode_ff        <= mode_in;
         rsp_unit_id_ff     <= unit_id_in;
         rsp_servo_angle_ff <= angle_in;
         rsp_led_on_ff      <= led_in;
         rsp_critical_ff    <= critical_in;
         rsp_trip_now_ff    <= trip_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mode        = rsp_mode_ff;
   assign rsp_unit_id     = rsp_unit_id_ff;
   assign rsp_servo_angle = rsp_servo_angle_ff;
   assign rsp_led_on      = rsp_led_on_ff;
   assign rsp_critical    = rsp_critical_ff;
   assign rsp_trip_now    = rsp_trip_now_ff;

endmodule

`default_nettype wire

FILE: rtl/mgmc_checker.sv
// ----------------------------------------------------------------------------
// mgmc_checker
// Port-level checks of the motor guard mode controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mgmc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_mode,
   input wire logic [15:0] rsp_unit_id,
   input wire logic [7:0]  rsp_servo_angle,
   input wire logic        rsp_led_on,
   input wire logic        rsp_critical,
   input wire logic        rsp_trip_now
);

   // a stalled item keeps its mode, unit id, servo angle and trip flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode)
         && $stable(rsp_unit_id) && $stable(rsp_servo_angle)
         && $stable(rsp_trip_now))
      else $error("result item changed while stalled");

   // a lockout comes from a violating sample and lands in locked failure
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trip_now |->
         rsp_critical && (rsp_mode == mgmc_pkg::MODE_LOCKED))
      else $error("trip without violation or without lockout");

   // servo parks at mid travel outside operation, and stays within range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_servo_angle <= mgmc_pkg::ANGLE_MAX)
         && ((rsp_mode == mgmc_pkg::MODE_OPERATING)
             || (rsp_servo_angle == mgmc_pkg::ANGLE_IDLE)))
      else $error("servo angle out of range or not parked");

   // led is lit while operating and dark outside operation and failure
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_mode == mgmc_pkg::MODE_OPERATING) == rsp_led_on)
         || (rsp_mode == mgmc_pkg::MODE_LOCKED))
      else $error("led does not follow the mode");

   // the unit id is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_id != 16'd0))
      else $error("unit id became zero");

endmodule

bind motor_guard_mode_controller_unit mgmc_checker u_mgmc_checker (.*);

`default_nettype wire

FILE: dv/guard_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guard_result_checker
// Watches the item, result and register channels of the motor guard. Keeps
// its own copy of the guard modes, fault timer, servo sweep and limits, works
// out the result of every accepted item and compares each accepted result
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------

module guard_result_checker
   import mgmc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_target_id,
   input  logic [2:0]         req_command,
   input  logic [15:0]        req_new_id,
   input  logic signed [11:0] req_temperature,
   input  logic [11:0]        req_current_raw,
   input  logic signed [15:0] req_vibration,
   input  logic [31:0]        req_now_ms,
   input  logic               req_link_up,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_mode,
   input  logic [15:0]        rsp_unit_id,
   input  logic [7:0]         rsp_servo_angle,
   input  logic               rsp_led_on,
   input  logic               rsp_critical,
   input  logic               rsp_trip_now,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 fail_count,
   output int                 outstanding
);

   localparam logic [31:0] BLINK_PERIOD_MS = 32'd500;
   // stored sweep position saturates to a 9-bit signed range
   localparam int SERVO_CEIL  = 255;
   localparam int SERVO_FLOOR = -256;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] unit_id;
      logic [7:0]  servo_angle;
      logic        led_on;
      logic        critical;
      logic        trip_now;
   } guard_result_type;

   guard_result_type expected_results[$];
   int               result_count = 0;

   // guard state
   mode_type    g_mode;
   logic [15:0] g_unit_id;
   logic        g_fault_armed;
   logic [31:0] g_fault_since;
   int          g_servo;
   logic        g_sweep_down;

   // limits
   int          g_temp_limit;
   int          g_current_limit;
   int          g_vib_limit;
   logic [15:0] g_trip_delay;
   int          g_sweep_step;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string text);
      fail_count++;
      $display("[%0t] result %0d: %s", $realtime, result_count, text);
   endtask

   // advance the guard by one item and return the result it reports
   function automatic guard_result_type predict_guard(
      input logic [1:0]         func,
      input logic [15:0]        target,
      input logic [2:0]         cmd,
      input logic [15:0]        nid,
      input logic signed [11:0] temp,
      input logic [11:0]        cur,
      input logic signed [15:0] vib,
      input logic [31:0]        now,
      input logic               link
   );
      guard_result_type res;
      int               next_pos;
      logic [31:0]      elapsed;
      res = '0;
      case (func)
         FUNC_COMMAND: begin
            // only items addressed to the current id count
            if (target == g_unit_id) begin
               if (cmd == CMD_SWITCH_ID) begin
                  if (nid != 16'd0) g_unit_id = nid;
               end else if (g_mode == MODE_LOCKED) begin
                  if (cmd == CMD_MAINT) g_mode = MODE_MAINT;
               end else if (g_mode == MODE_MAINT) begin
                  if (cmd == CMD_RESET) g_mode = MODE_STOPPED;
               end else begin
                  case (cmd)
                     CMD_START: g_mode = MODE_OPERATING;
                     CMD_STOP:  g_mode = MODE_STOPPED;
                     CMD_MAINT: g_mode = MODE_MAINT;
                     default: ;
                  endcase
               end
            end
         end
         FUNC_LINK: begin
            if (!link) begin
               g_mode = MODE_OFFLINE;
            end else if (g_mode == MODE_OFFLINE) begin
               g_mode = MODE_STOPPED;
            end
         end
         FUNC_SAMPLE: begin
            res.critical = (int'(temp) >= g_temp_limit) || (int'(cur) >= g_current_limit)
                           || (int'(vib) >= g_vib_limit);
            // first violation arms the timer, a later one may latch the lockout
            if (res.critical && g_mode == MODE_OPERATING) begin
               if (!g_fault_armed) begin
                  g_fault_armed = 1'b1;
                  g_fault_since = now;
               end else begin
                  elapsed = now - g_fault_since;
                  if (elapsed >= 32'(g_trip_delay)) begin
                     g_mode        = MODE_LOCKED;
                     g_fault_armed = 1'b0;
                     res.trip_now  = 1'b1;
                  end
               end
            end else begin
               g_fault_armed = 1'b0;
            end
            // servo sweep, turning round at either end
            if (g_mode == MODE_OPERATING) begin
               next_pos = g_sweep_down ? g_servo - g_sweep_step : g_servo + g_sweep_step;
               if (next_pos > SERVO_CEIL) next_pos = SERVO_CEIL;
               if (next_pos < SERVO_FLOOR) next_pos = SERVO_FLOOR;
               g_servo = next_pos;
               if (next_pos >= int'(ANGLE_MAX) || next_pos <= 0) g_sweep_down = !g_sweep_down;
            end
         end
         default: ;
      endcase

      // reported angle and indicator
      if (g_mode == MODE_OPERATING) begin
         if (g_servo < 0) begin
            res.servo_angle = 8'd0;
         end else if (g_servo > int'(ANGLE_MAX)) begin
            res.servo_angle = ANGLE_MAX;
         end else begin
            res.servo_angle = 8'(g_servo);
         end
         res.led_on = 1'b1;
      end else begin
         res.servo_angle = ANGLE_IDLE;
         res.led_on = (g_mode == MODE_LOCKED) && ((now % BLINK_PERIOD_MS) < 32'(BLINK_ON));
      end
      res.mode    = g_mode;
      res.unit_id = g_unit_id;
      return res;
   endfunction

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      guard_result_type want;
      if (reset) begin
         g_mode          = MODE_OFFLINE;
         g_unit_id       = UNIT_ID_RST;
         g_fault_armed   = 1'b0;
         g_fault_since   = '0;
         g_servo         = 0;
         g_sweep_down    = 1'b0;
         g_temp_limit    = int'($signed(TEMP_LIMIT_RST));
         g_current_limit = int'(CURRENT_LIMIT_RST);
         g_vib_limit     = int'($signed(VIB_LIMIT_RST));
         g_trip_delay    = TRIP_DELAY_RST;
         g_sweep_step    = int'(SWEEP_STEP_RST);
         expected_results.delete();
      end else begin
         // results first: one taken now belongs to an earlier item
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no item waiting for it");
            end else begin
               want = expected_results.pop_front();
               if (rsp_mode !== want.mode)
                  report_mismatch($sformatf("mode %0d, expected %0d", rsp_mode, want.mode));
               if (rsp_unit_id !== want.unit_id)
                  report_mismatch($sformatf("asset id %0d, expected %0d",
                                            rsp_unit_id, want.unit_id));
               if (rsp_servo_angle !== want.servo_angle)
                  report_mismatch($sformatf("servo angle %0d, expected %0d",
                                            rsp_servo_angle, want.servo_angle));
               if (rsp_led_on !== want.led_on)
                  report_mismatch($sformatf("led %b, expected %b", rsp_led_on, want.led_on));
               if (rsp_critical !== want.critical)
                  report_mismatch($sformatf("critical %b, expected %b",
                                            rsp_critical, want.critical));
               if (rsp_trip_now !== want.trip_now)
                  report_mismatch($sformatf("trip %b, expected %b",
                                            rsp_trip_now, want.trip_now));
            end
            result_count++;
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEMP_LIMIT:    g_temp_limit    = int'($signed(csr_data[11:0]));
               CSR_CURRENT_LIMIT: g_current_limit = int'(csr_data[11:0]);
               CSR_VIB_LIMIT:     g_vib_limit     = int'($signed(csr_data));
               CSR_TRIP_DELAY:    g_trip_delay    = csr_data;
               CSR_SWEEP_STEP:    g_sweep_step    = int'(csr_data[5:0]);
               default: ;
            endcase
         end
         // accepted items
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_guard(req_func, req_target_id, req_command,
               req_new_id, req_temperature, req_current_raw, req_vibration, req_now_ms,
               req_link_up));
         end
      end
      outstanding = expected_results.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the motor guard with a short directed run through every mode change,
// lockout timing and id rename, then with random command, link and sensor
// traffic under several limit settings, random idling on both sides and one
// long result stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module testbench;
   import mgmc_pkg::*;

   localparam int LIMIT_CYCLES = 400_000;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 220;

   // codes the block must ignore
   localparam logic [1:0] FUNC_UNKNOWN   = 2'd3;
   localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

   // field and limit ranges
   localparam int TEMP_MIN    = -400;
   localparam int TEMP_MAX    = 1250;
   localparam int CURRENT_MAX = 4095;
   localparam int VIB_MIN     = -20000;
   localparam int VIB_MAX     = 20000;
   localparam int DELAY_MAX   = 65535;
   localparam int STEP_MIN    = 1;
   localparam int STEP_MAX    = 45;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func = '0;
   logic [15:0]        req_target_id = '0;
   logic [2:0]         req_command = '0;
   logic [15:0]        req_new_id = '0;
   logic signed [11:0] req_temperature = '0;
   logic [11:0]        req_current_raw = '0;
   logic signed [15:0] req_vibration = '0;
   logic [31:0]        req_now_ms = '0;
   logic               req_link_up = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_mode;
   logic [15:0]        rsp_unit_id;
   logic [7:0]         rsp_servo_angle;
   logic               rsp_led_on;
   logic               rsp_critical;
   logic               rsp_trip_now;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;
   int                 fail_count;
   int                 outstanding;
   int                 cycle_count = 0;

   // idling controls of the two sides
   bit          sender_idles   = 1'b1;
   bit          receiver_idles = 1'b1;
   bit          hold_request   = 1'b0;
   // id the commands are aimed at, running sample clock, current limits
   logic [15:0] addr_id = UNIT_ID_RST;
   logic [31:0] stamp_ms = '0;
   int          cfg_temp, cfg_current, cfg_vib, cfg_delay;

   motor_guard_mode_controller_unit u_top (.*);

   guard_result_checker u_checker (.*);

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int draw_between(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // offer one item, called at a falling edge, returns at a falling edge
   task automatic send_item(
      input logic [1:0]  func,
      input logic [15:0] target,
      input logic [2:0]  cmd,
      input logic [15:0] nid,
      input logic [11:0] temp,
      input logic [11:0] cur,
      input logic [15:0] vib,
      input logic [31:0] now,
      input logic        link
   );
      int gap;
      gap = sender_idles ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func        <= func;
      req_target_id   <= target;
      req_command     <= cmd;
      req_new_id      <= nid;
      req_temperature <= temp;
      req_current_raw <= cur;
      req_vibration   <= vib;
      req_now_ms      <= now;
      req_link_up     <= link;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_sample_at(input int temp, input int cur, input int vib,
                                 input logic [31:0] now);
      send_item(FUNC_SAMPLE, 16'($urandom), 3'($urandom), 16'($urandom),
                12'(temp), 12'(cur), 16'(vib), now, 1'($urandom));
   endtask

   // track renames so later commands stay addressed
   task automatic send_command(input logic [15:0] target, input logic [2:0] cmd,
                               input logic [15:0] nid);
      if (cmd == CMD_SWITCH_ID && target == addr_id && nid != 16'd0) addr_id = nid;
      send_item(FUNC_COMMAND, target, cmd, nid, 12'($urandom), 12'($urandom),
                16'($urandom), $urandom, 1'($urandom));
   endtask

   task automatic send_link(input logic up);
      send_item(FUNC_LINK, 16'($urandom), 3'($urandom), 16'($urandom), 12'($urandom),
                12'($urandom), 16'($urandom), $urandom, up);
   endtask

   // sample below or above the current limits, the clock moving on
   task automatic send_random_sample(input bit hot);
      int temp, cur, vib;
      temp = (cfg_temp > TEMP_MIN) ? draw_between(TEMP_MIN, cfg_temp - 1) : TEMP_MIN;
      cur  = (cfg_current > 0) ? draw_between(0, cfg_current - 1) : 0;
      vib  = (cfg_vib > VIB_MIN) ? draw_between(VIB_MIN, cfg_vib - 1) : VIB_MIN;
      if (hot) begin
         case ($urandom_range(0, 2))
            0: temp = ($urandom_range(0, 3) == 0) ? cfg_temp : draw_between(cfg_temp, TEMP_MAX);
            1: cur = ($urandom_range(0, 3) == 0) ? cfg_current
                                                 : draw_between(cfg_current, CURRENT_MAX);
            default: vib = ($urandom_range(0, 3) == 0) ? cfg_vib : draw_between(cfg_vib, VIB_MAX);
         endcase
      end
      // now and then a sample of any bit pattern
      if ($urandom_range(0, 15) == 0) begin
         temp = int'($signed(12'($urandom)));
         cur  = int'(12'($urandom));
         vib  = int'($signed(16'($urandom)));
      end
      if ($urandom_range(0, 31) == 0) begin
         stamp_ms = $urandom;
      end else begin
         stamp_ms = stamp_ms + $urandom_range(0, cfg_delay / 3 + 300);
      end
      send_sample_at(temp, cur, vib, stamp_ms);
   endtask

   // write every limit, block idle
   task automatic configure_limits(input int temp, input int cur, input int vib,
                                   input int delay, input int step);
      cfg_temp    = temp;
      cfg_current = cur;
      cfg_vib     = vib;
      cfg_delay   = delay;
      csr_valid   <= 1'b1;
      csr_index   <= CSR_TEMP_LIMIT;
      csr_data    <= 16'(temp);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_CURRENT_LIMIT;
      csr_data  <= 16'(cur);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_VIB_LIMIT;
      csr_data  <= 16'(vib);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_TRIP_DELAY;
      csr_data  <= 16'(delay);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_SWEEP_STEP;
      csr_data  <= 16'(step);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side: a fresh stall for every item, one long hold on request
   initial begin : result_side
      int stall;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end else begin
            stall = receiver_idles ? $urandom_range(0, 15) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // item side
   initial begin : item_side
      int          phase;
      int          sent;
      int          roll;
      int          burst;
      int          heat;
      logic [2:0]  cmd;
      cfg_temp    = int'($signed(TEMP_LIMIT_RST));
      cfg_current = int'(CURRENT_LIMIT_RST);
      cfg_vib     = int'($signed(VIB_LIMIT_RST));
      cfg_delay   = int'(TRIP_DELAY_RST);
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed run at reset limits
      send_sample_at(TEMP_MIN, 0, VIB_MIN, 32'd0);
      send_sample_at(TEMP_MAX, CURRENT_MAX, VIB_MAX, 32'hFFFF_FFFF);
      send_command(16'd2, CMD_START, 16'd0);
      send_item(FUNC_UNKNOWN, 16'hFFFF, CMD_START, 16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF,
                32'hFFFF_FFFF, 1'b1);
      // offline takes maintenance like stopped does
      send_command(addr_id, CMD_MAINT, 16'd0);
      send_command(addr_id, CMD_START, 16'd0);
      send_command(addr_id, CMD_RESET, 16'd0);
      send_link(1'b0);
      send_link(1'b1);
      send_link(1'b1);
      send_command(addr_id, CMD_START, 16'd0);
      // lockout exactly at the trip delay
      send_sample_at(200, 100, 0, 32'd100);
      send_sample_at(700, 100, 0, 32'd1000);
      send_sample_at(200, 3822, 0, 32'd5999);
      send_sample_at(200, 100, 1000, 32'd6000);
      send_sample_at(200, 100, 0, 32'd6300);
      // locked failure leaves only through maintenance
      send_command(addr_id, CMD_START, 16'd0);
      send_command(addr_id, CMD_MAINT, 16'd0);
      send_command(addr_id, CMD_RESET, 16'd0);
      // renames
      send_command(addr_id, CMD_SWITCH_ID, 16'd0);
      send_command(addr_id, CMD_SWITCH_ID, 16'hFFFF);
      send_command(UNIT_ID_RST, CMD_START, 16'd0);
      send_command(addr_id, CMD_START, 16'd0);
      send_command(addr_id, CMD_UNKNOWN_HI, 16'd0);
      // lockout across the timestamp wrap
      send_sample_at(600, 0, 0, 32'hFFFF_F000);
      send_sample_at(600, 0, 0, 32'h0000_0388);
      send_link(1'b0);

      // random phases, each under its own limits
      for (phase = 0; phase < PHASES; phase++) begin
         req_valid <= 1'b0;
         while (outstanding != 0) @(negedge clock);
         case (phase)
            0: configure_limits(TEMP_MIN, 0, VIB_MIN, 0, STEP_MAX);
            1: configure_limits(TEMP_MAX, CURRENT_MAX, VIB_MAX, DELAY_MAX, STEP_MIN);
            2: configure_limits(int'($signed(TEMP_LIMIT_RST)), int'(CURRENT_LIMIT_RST),
                                int'($signed(VIB_LIMIT_RST)), int'(TRIP_DELAY_RST),
                                int'(SWEEP_STEP_RST));
            default: configure_limits(draw_between(TEMP_MIN, TEMP_MAX),
                                      draw_between(0, CURRENT_MAX),
                                      draw_between(VIB_MIN, VIB_MAX),
                                      ($urandom_range(0, 1) == 0) ? draw_between(0, 2000)
                                                                  : draw_between(0, DELAY_MAX),
                                      draw_between(STEP_MIN, STEP_MAX));
         endcase
         stamp_ms = phase[0] ? 32'hFFFF_FFFF - $urandom_range(0, 30000) : $urandom;
         // long result stall with the sender pushing flat out
         if (phase == 1) begin
            hold_request = 1'b1;
            sender_idles = 1'b0;
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 39) == 0) begin
               sender_idles   = $urandom_range(0, 1);
               receiver_idles = $urandom_range(0, 1);
            end
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               // burst of samples, mostly cool, mixed or mostly hot
               burst = $urandom_range(1, 12);
               heat  = $urandom_range(0, 2);
               repeat (burst) begin
                  case (heat)
                     0: send_random_sample($urandom_range(0, 9) == 0);
                     1: send_random_sample($urandom_range(0, 1) == 1);
                     default: send_random_sample($urandom_range(0, 9) != 0);
                  endcase
               end
               sent += burst;
            end else if (roll < 78) begin
               // addressed commands, weighted to keep the motor running
               roll = $urandom_range(0, 99);
               if (roll < 40) begin
                  cmd = CMD_START;
               end else if (roll < 50) begin
                  cmd = CMD_STOP;
               end else if (roll < 70) begin
                  cmd = CMD_MAINT;
               end else if (roll < 92) begin
                  cmd = CMD_RESET;
               end else begin
                  cmd = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
               end
               send_command(addr_id, cmd, 16'($urandom));
               sent++;
            end else if (roll < 88) begin
               send_link($urandom_range(0, 9) < 7);
               sent++;
            end else if (roll < 93) begin
               send_command(addr_id, CMD_SWITCH_ID,
                            ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom));
               sent++;
            end else if (roll < 97) begin
               // misaddressed command of any code
               send_command(16'($urandom), 3'($urandom), 16'($urandom));
            end else begin
               send_item(FUNC_UNKNOWN, 16'($urandom), 3'($urandom), 16'($urandom),
                         12'($urandom), 12'($urandom), 16'($urandom), $urandom,
                         1'($urandom));
            end
         end
      end

      // drain and give the block time to show any stray result
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mgmc_pkg.sv
rtl/motor_guard_mode_controller_unit.sv
rtl/mgmc_checker.sv
dv/guard_result_checker.sv
dv/testbench.sv
